// ----- sv/ltbi_pkg.sv -----
`timescale 1ns / 1ps
package ltbi_pkg;

  localparam int DEF_MAX_TEMPERATURES = 64;
  localparam int DEF_MAX_DENSITIES    = 64;
  localparam int DEF_MAX_GROUPS       = 16;

  // Item kinds carried in tuser
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_LOAD_T = 2'd1;
  localparam logic [1:0] OP_LOAD_D = 2'd2;
  localparam logic [1:0] OP_LOAD_V = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMP_COUNT  = 2'd0;
  localparam logic [1:0] CFG_DENS_COUNT  = 2'd1;
  localparam logic [1:0] CFG_GROUP_COUNT = 2'd2;

endpackage

// ----- sv/log_table_bilinear_interp_top.sv -----
`timescale 1ns / 1ps
// Clamped bilinear lookup in a log-domain (Q15.16) table.
// Input stream: in_tuser selects the item kind (query, load temperature axis
// entry, load density axis entry, load table entry); in_tdata carries index,
// load value, query point and group. A load is written in the cycle it is
// accepted and gives no result. A query gives one result item on the output
// stream: out_tdata is the interpolated value, out_tuser the top-edge flags.
// Configuration (cfg_we/cfg_addr/cfg_data) sets the axis lengths and groups
// per cell; write it only while no query is in flight.
// A query is worked by one sequencer: each axis is clamped and searched one
// entry at a time (a read state, then a compare state) through its axis
// memory port, then a shared 16-step divider makes the weights, four table
// reads follow and one shared multiplier does three interpolations. Each
// axis at its top edge skips its 16-step division. in_tready is high only
// while the sequencer is idle, so a new query is taken only once the last
// is through; loads leave it idle and can be accepted back to back.
// The result waits in an output register; if the receiver stalls it, the
// sequencer holds at the last step until the register is free.
// Reset (rst_n low, synchronous) returns the counts to 2, 2 and 1 and empties
// the output; axis and table memories keep their contents.
module log_table_bilinear_interp_top
  import ltbi_pkg::*;
#(
  parameter int MAX_TEMPERATURES = DEF_MAX_TEMPERATURES,
  parameter int MAX_DENSITIES    = DEF_MAX_DENSITIES,
  parameter int MAX_GROUPS       = DEF_MAX_GROUPS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [6:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // index, load_value, log_temperature, log_density, group, zero pad
  input  logic [119:0] in_tdata,
  // operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // log_result
  output logic [31:0]  out_tdata,
  // edge_case
  output logic [1:0]   out_tuser
);

  localparam int AXN    = (MAX_TEMPERATURES > MAX_DENSITIES) ? MAX_TEMPERATURES
                                                             : MAX_DENSITIES;
  localparam int AW     = $clog2(AXN);
  localparam int KW     = $clog2(AXN + 1);
  localparam int TIW    = $clog2(MAX_TEMPERATURES);
  localparam int DIW    = $clog2(MAX_DENSITIES);
  localparam int GNW    = $clog2(MAX_GROUPS + 1);
  localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int TDEPTH = MAX_TEMPERATURES * MAX_DENSITIES * MAX_GROUPS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int BW     = AW + KW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_W0   = 4'd1;
  localparam logic [3:0] S_C0   = 4'd2;
  localparam logic [3:0] S_W1   = 4'd3;
  localparam logic [3:0] S_C1   = 4'd4;
  localparam logic [3:0] S_W2   = 4'd5;
  localparam logic [3:0] S_C2   = 4'd6;
  localparam logic [3:0] S_DSET = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_AD1  = 4'd9;
  localparam logic [3:0] S_AD2  = 4'd10;
  localparam logic [3:0] S_AD3  = 4'd11;
  localparam logic [3:0] S_TW   = 4'd12;
  localparam logic [3:0] S_TC   = 4'd13;
  localparam logic [3:0] S_LM   = 4'd14;
  localparam logic [3:0] S_LA   = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [6:0] tcnt_r, dcnt_r;
  logic [4:0] gcnt_r;
  logic       out_valid_r;
  logic signed [31:0] out_data_r;
  logic [1:0] out_edge_r;

  logic [1:0]         op_in;
  logic [15:0]        idx_in;
  logic signed [31:0] lv_in, lt_in, ld_in;
  logic [3:0]         grp_in;
  logic               accept;

  assign op_in  = in_tuser;
  assign idx_in = in_tdata[15:0];
  assign lv_in  = in_tdata[47:16];
  assign lt_in  = in_tdata[79:48];
  assign ld_in  = in_tdata[111:80];
  assign grp_in = in_tdata[115:112];
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  // Counts in use
  logic [KW-1:0]  nt, nd, n_cur;
  logic [GNW-1:0] ng;
  always_comb begin
    if (tcnt_r < 7'd2) nt = KW'(2);
    else if (int'(tcnt_r) > MAX_TEMPERATURES) nt = KW'(MAX_TEMPERATURES);
    else nt = KW'(tcnt_r);
    if (dcnt_r < 7'd2) nd = KW'(2);
    else if (int'(dcnt_r) > MAX_DENSITIES) nd = KW'(MAX_DENSITIES);
    else nd = KW'(dcnt_r);
    if (gcnt_r < 5'd1) ng = GNW'(1);
    else if (int'(gcnt_r) > MAX_GROUPS) ng = GNW'(MAX_GROUPS);
    else ng = GNW'(gcnt_r);
  end

  // Working registers
  logic               sel_r, dsel_r;
  logic [AW-1:0]      addr_r, it_r, id_r;
  logic [KW-1:0]      k_r;
  logic signed [31:0] xt_r, xd_r, prev_r, tlo_r, thi_r, dlo_r, dhi_r;
  logic [GW-1:0]      g_r;
  logic [31:0]        rem_r, den_r;
  logic [15:0]        q_r, wt_r, wd_r;
  logic [3:0]         dcnt_step_r;
  logic [BW-1:0]      base_r;
  logic [TAW-1:0]     ci_r, ck_r, taddr_r;
  logic [1:0]         rk_r, lk_r;
  logic signed [31:0] v_r [4];
  logic signed [31:0] lo_r, hi_r;
  logic signed [49:0] mul_r;

  // Memories
  logic signed [31:0] tax [MAX_TEMPERATURES];
  logic signed [31:0] dax [MAX_DENSITIES];
  logic signed [31:0] tbl [TDEPTH];
  logic signed [31:0] tax_rd_r, dax_rd_r, tbl_rd_r;

  always_ff @(posedge clk) begin
    if (accept && op_in == OP_LOAD_T && int'(idx_in) < MAX_TEMPERATURES) begin
      tax[TIW'(idx_in)] <= lv_in;
    end
    tax_rd_r <= tax[addr_r[TIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && op_in == OP_LOAD_D && int'(idx_in) < MAX_DENSITIES) begin
      dax[DIW'(idx_in)] <= lv_in;
    end
    dax_rd_r <= dax[addr_r[DIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && op_in == OP_LOAD_V && int'(idx_in) < TDEPTH) begin
      tbl[TAW'(idx_in)] <= lv_in;
    end
    tbl_rd_r <= tbl[taddr_r];
  end

  // Datapath helpers
  logic signed [31:0] ax_rd, x_cur;
  logic               found, last, t_edge, d_edge, div_done, out_free;
  logic [32:0]        rem2;
  logic               ge;
  logic [15:0]        qn;
  logic [TAW-1:0]     a01, a10, a11, next_taddr;
  logic signed [31:0] la, lb;
  logic [15:0]        lw;
  logic signed [32:0] ldiff;
  logic signed [49:0] lsum;

  assign ax_rd    = sel_r ? dax_rd_r : tax_rd_r;
  assign x_cur    = sel_r ? xd_r : xt_r;
  assign n_cur    = sel_r ? nd : nt;
  assign found    = (k_r != '0) && (prev_r <= x_cur) && (x_cur < ax_rd);
  assign last     = (k_r == n_cur - KW'(1));
  assign t_edge   = (KW'(it_r) == nt - KW'(1));
  assign d_edge   = (KW'(id_r) == nd - KW'(1));
  assign div_done = (dcnt_step_r == 4'd15);
  assign out_free = !out_valid_r || out_tready;
  assign rem2     = {rem_r, 1'b0};
  assign ge       = (rem2 >= {1'b0, den_r});
  assign qn       = {q_r[14:0], ge};

  assign a01 = d_edge ? ci_r : TAW'(ci_r + TAW'(ng));
  assign a10 = t_edge ? ci_r : ck_r;
  assign a11 = t_edge ? a01 : (d_edge ? ck_r : TAW'(ck_r + TAW'(ng)));

  always_comb begin
    case (rk_r)
      2'd0:    next_taddr = a01;
      2'd1:    next_taddr = a10;
      2'd2:    next_taddr = a11;
      default: next_taddr = ci_r;
    endcase
  end

  always_comb begin
    case (lk_r)
      2'd0:    begin la = v_r[0]; lb = v_r[1]; lw = wd_r; end
      2'd1:    begin la = v_r[2]; lb = v_r[3]; lw = wd_r; end
      default: begin la = lo_r;   lb = hi_r;   lw = wt_r; end
    endcase
  end

  assign ldiff = 33'(lb) - 33'(la);
  assign lsum  = 50'(la) + (mul_r >>> 16);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && op_in == OP_QUERY) state_nxt = S_W0;
      S_W0:   state_nxt = S_C0;
      S_C0:   state_nxt = S_W1;
      S_W1:   state_nxt = S_C1;
      S_C1:   state_nxt = S_W2;
      S_W2:   state_nxt = S_C2;
      S_C2: begin
        if (found || last) state_nxt = sel_r ? S_DSET : S_W0;
        else state_nxt = S_W2;
      end
      S_DSET: begin
        if (!dsel_r) state_nxt = t_edge ? S_DSET : S_DIV;
        else state_nxt = d_edge ? S_AD1 : S_DIV;
      end
      S_DIV:  if (div_done) state_nxt = dsel_r ? S_AD1 : S_DSET;
      S_AD1:  state_nxt = S_AD2;
      S_AD2:  state_nxt = S_AD3;
      S_AD3:  state_nxt = S_TW;
      S_TW:   state_nxt = S_TC;
      S_TC:   state_nxt = (rk_r == 2'd3) ? S_LM : S_TW;
      S_LM:   state_nxt = S_LA;
      S_LA: begin
        if (lk_r != 2'd2) state_nxt = S_LM;
        else if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tcnt_r      <= 7'd2;
      dcnt_r      <= 7'd2;
      gcnt_r      <= 5'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TEMP_COUNT:  tcnt_r <= cfg_data;
          CFG_DENS_COUNT:  dcnt_r <= cfg_data;
          CFG_GROUP_COUNT: gcnt_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state_r == S_LA && lk_r == 2'd2 && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        xt_r   <= lt_in;
        xd_r   <= ld_in;
        sel_r  <= 1'b0;
        dsel_r <= 1'b0;
        addr_r <= '0;
        if (int'(grp_in) >= int'(ng)) g_r <= GW'(ng - GNW'(1));
        else g_r <= GW'(grp_in);
      end
      S_C0: begin
        // low clamp first, high clamp second
        if (x_cur < ax_rd) begin
          if (sel_r) xd_r <= ax_rd;
          else xt_r <= ax_rd;
        end
        addr_r <= AW'(n_cur - KW'(1));
      end
      S_C1: begin
        if (x_cur > ax_rd) begin
          if (sel_r) xd_r <= ax_rd;
          else xt_r <= ax_rd;
        end
        addr_r <= '0;
        k_r    <= '0;
      end
      S_C2: begin
        prev_r <= ax_rd;
        if (found || last) begin
          if (sel_r) begin
            id_r  <= found ? AW'(k_r - KW'(1)) : AW'(n_cur - KW'(1));
            dlo_r <= prev_r;
            dhi_r <= ax_rd;
          end else begin
            it_r  <= found ? AW'(k_r - KW'(1)) : AW'(n_cur - KW'(1));
            tlo_r <= prev_r;
            thi_r <= ax_rd;
          end
          sel_r  <= 1'b1;
          addr_r <= '0;
        end else begin
          k_r    <= k_r + KW'(1);
          addr_r <= AW'(k_r + KW'(1));
        end
      end
      S_DSET: begin
        q_r         <= '0;
        dcnt_step_r <= '0;
        if (!dsel_r) begin
          rem_r <= 32'(xt_r - tlo_r);
          den_r <= 32'(thi_r - tlo_r);
          if (t_edge) begin
            wt_r   <= '0;
            dsel_r <= 1'b1;
          end
        end else begin
          rem_r <= 32'(xd_r - dlo_r);
          den_r <= 32'(dhi_r - dlo_r);
          if (d_edge) wd_r <= '0;
        end
      end
      S_DIV: begin
        rem_r       <= ge ? 32'(rem2 - {1'b0, den_r}) : rem2[31:0];
        q_r         <= qn;
        dcnt_step_r <= dcnt_step_r + 4'd1;
        if (div_done) begin
          if (dsel_r) wd_r <= qn;
          else begin
            wt_r   <= qn;
            dsel_r <= 1'b1;
          end
        end
      end
      S_AD1: base_r <= BW'(it_r) * BW'(nd) + BW'(id_r);
      S_AD2: ci_r <= TAW'(base_r) * TAW'(ng) + TAW'(g_r);
      S_AD3: begin
        ck_r    <= ci_r + TAW'(ng) * TAW'(nd);
        taddr_r <= ci_r;
        rk_r    <= 2'd0;
      end
      S_TC: begin
        v_r[rk_r] <= tbl_rd_r;
        rk_r      <= rk_r + 2'd1;
        taddr_r   <= next_taddr;
        lk_r      <= 2'd0;
      end
      S_LM: mul_r <= ldiff * $signed({1'b0, lw});
      S_LA: begin
        if (lk_r == 2'd0) lo_r <= lsum[31:0];
        if (lk_r == 2'd1) hi_r <= lsum[31:0];
        if (lk_r != 2'd2) lk_r <= lk_r + 2'd1;
        else if (out_free) begin
          out_data_r <= lsum[31:0];
          out_edge_r <= {t_edge, d_edge};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_edge_r;

`ifndef SYNTHESIS
  a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != 32'd0)
    else $error("weight division with zero bracket width");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_C2 |-> k_r < n_cur)
    else $error("axis search ran past the entries in use");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_LA)
    else $error("result raised outside the final interpolation step");
`endif

endmodule
